[rtl/des_pkg.sv]
`default_nettype none
package des_pkg;

    localparam int Rounds = 16;

    typedef enum logic
    {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } des_op_t;

    localparam logic [7:0] TAB_IP [64] = '{
        8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2, 8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
        8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6, 8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
        8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,  8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
        8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5, 8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

    localparam logic [7:0] TAB_FP [64] = '{
        8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32, 8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
        8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30, 8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
        8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28, 8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
        8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26, 8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

    localparam logic [7:0] TAB_E [48] = '{
        8'd32,8'd1,8'd2,8'd3,8'd4,8'd5, 8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
        8'd8,8'd9,8'd10,8'd11,8'd12,8'd13, 8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
        8'd16,8'd17,8'd18,8'd19,8'd20,8'd21, 8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
        8'd24,8'd25,8'd26,8'd27,8'd28,8'd29, 8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

    localparam logic [7:0] TAB_PC1 [56] = '{
        8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1, 8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
        8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19, 8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
        8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7, 8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
        8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29,8'd21, 8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

    localparam logic [7:0] TAB_PC2 [48] = '{
        8'd14,8'd17,8'd11,8'd24,8'd1,8'd5, 8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
        8'd23,8'd19,8'd12,8'd4,8'd26,8'd8, 8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
        8'd41,8'd52,8'd31,8'd37,8'd47,8'd55, 8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
        8'd44,8'd49,8'd39,8'd56,8'd34,8'd53, 8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

    localparam logic [7:0] TAB_P [32] = '{
        8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17, 8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
        8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9, 8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

    localparam logic [1:0] ROT_ENC [Rounds] = '{
        2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};
    localparam logic [1:0] ROT_DEC [Rounds] = '{
        2'd0,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

    localparam logic [3:0] TAB_S [8][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

    // table bit k (1 = MSB) of a 64-bit word
    function automatic logic [63:0] perm64(input logic [63:0] x, input logic [7:0] tab [64]);
        logic [63:0] r;
        for (int i = 0; i < 64; i++)
        begin
            r[63-i] = x[6'(7'd64 - {1'b0, tab[i][6:0]})];
        end
        return r;
    endfunction

    function automatic logic [55:0] pc1(input logic [63:0] k);
        logic [55:0] r;
        for (int i = 0; i < 56; i++)
        begin
            r[55-i] = k[6'(7'd64 - {1'b0, TAB_PC1[i][6:0]})];
        end
        return r;
    endfunction

    function automatic logic [47:0] pc2(input logic [55:0] cd);
        logic [47:0] r;
        for (int i = 0; i < 48; i++)
        begin
            r[47-i] = cd[6'd56 - TAB_PC2[i][5:0]];
        end
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] c, input logic [1:0] s,
                                          input logic right);
        logic [27:0] r;
        case (s)
            2'd1: r = right ? {c[0], c[27:1]} : {c[26:0], c[27]};
            2'd2: r = right ? {c[1:0], c[27:2]} : {c[25:0], c[27:26]};
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++)
        begin
            x[47-i] = r[5'(6'd32 - TAB_E[i][5:0])];
        end
        x = x ^ k;
        for (int b = 0; b < 8; b++)
        begin
            six = x[42-6*b +: 6];
            s[28-4*b +: 4] = TAB_S[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++)
        begin
            p[31-i] = s[5'(6'd32 - TAB_P[i][5:0])];
        end
        return p;
    endfunction

endpackage
`default_nettype wire

[rtl/des_block_cipher.sv]
`default_nettype none
// Channel   | Ports                         | Transfer
// ----------+-------------------------------+--------------------------
// config    | cfg_we, cfg_data              | clk edge with cfg_we high
// input     | start, busy, data_block,      | clk edge with start high
//           | opcode                        | and busy low
// result    | done, result_block            | clk edge with done high
//
// One round per register stage: 16 round stages plus an input stage and an
// output stage lie between a block being taken and its result.
// One block may enter every cycle; busy is held low. The key halves travel
// down the pipe with each block, so a key write affects later blocks only.
// Reset clears the valid bits and the key; the receiver cannot stall.
module des_block_cipher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] data_block,
    input  wire logic        opcode,
    output logic             done,
    output logic [63:0]      result_block
);
    import des_pkg::*;

    logic [63:0] key_reg;
    logic        vin_reg;
    logic [31:0] lin_reg, rin_reg;
    logic [27:0] cin_reg, din_reg;
    logic        opin_reg;

    logic [Rounds-1:0] v_reg;
    logic [31:0] l_reg [Rounds];
    logic [31:0] r_reg [Rounds];
    logic [27:0] c_reg [Rounds];
    logic [27:0] d_reg [Rounds];
    logic        op_reg [Rounds];

    logic        out_v_reg;
    logic [63:0] out_reg;

    logic [63:0] ip_next;
    logic [55:0] cd_next;

    assign busy    = 1'b0;
    assign ip_next = perm64(data_block, TAB_IP);
    assign cd_next = pc1(key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            vin_reg   <= 1'b0;
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_reg <= cfg_data;
            end
            vin_reg   <= start;
            v_reg     <= {v_reg[Rounds-2:0], vin_reg};
            out_v_reg <= v_reg[Rounds-1];
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg  <= ip_next[63:32];
        rin_reg  <= ip_next[31:0];
        cin_reg  <= cd_next[55:28];
        din_reg  <= cd_next[27:0];
        opin_reg <= opcode;
    end

    for (genvar g = 0; g < Rounds; g++)
    begin : g_round
        logic [31:0] l_in, r_in;
        logic [27:0] c_in, d_in, c_rot, d_rot;
        logic        op_in;
        logic [1:0]  sh;

        if (g == 0)
        begin : g_first
            assign l_in  = lin_reg;
            assign r_in  = rin_reg;
            assign c_in  = cin_reg;
            assign d_in  = din_reg;
            assign op_in = opin_reg;
        end
        else
        begin : g_rest
            assign l_in  = l_reg[g-1];
            assign r_in  = r_reg[g-1];
            assign c_in  = c_reg[g-1];
            assign d_in  = d_reg[g-1];
            assign op_in = op_reg[g-1];
        end

        assign sh    = (op_in == OP_DECRYPT) ? ROT_DEC[g] : ROT_ENC[g];
        assign c_rot = rot28(c_in, sh, op_in == OP_DECRYPT);
        assign d_rot = rot28(d_in, sh, op_in == OP_DECRYPT);

        always_ff @(posedge clk)
        begin
            l_reg[g]  <= r_in;
            r_reg[g]  <= l_in ^ feistel(r_in, pc2({c_rot, d_rot}));
            c_reg[g]  <= c_rot;
            d_reg[g]  <= d_rot;
            op_reg[g] <= op_in;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= perm64({r_reg[Rounds-1], l_reg[Rounds-1]}, TAB_FP);
    end

    assign done         = out_v_reg;
    assign result_block = out_reg;

`ifndef SYNTH
    // every transfer in shows up as a result after the input, round and output stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##18 done)
        else $error("result missing after transfer");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 18))
        else $error("result without transfer");
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        vin_reg |-> ##8 v_reg[7])
        else $error("valid lost in round pipe");
`endif

endmodule
`default_nettype wire
